[hdl/signed_int_to_radix_text_top_macros.svh]
// Assertion macros used by the radix text converter datapath.
`ifndef SIGNED_INT_TO_RADIX_TEXT_TOP_MACROS_SVH
`define SIGNED_INT_TO_RADIX_TEXT_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define SIRT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("radix text converter: check failed");
// Check that cons holds in the cycle after ante.
`define SIRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("radix text converter: check failed");
`else
`define SIRT_ASSERT_SAME(label, ante, cons)
`define SIRT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hdl/sirt_pkg.sv]
// Shared types and constants of the radix text converter.
package sirt_pkg;

    localparam int VALUE_W         = 32;
    localparam int CHAR_W          = 8;
    localparam int BASE_LEN_W      = 5;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 2;
    localparam int ALPHA_SIZE      = 16;
    localparam int ALPHA_IDX_W     = 4;
    localparam int MAX_DIGITS      = 32;
    localparam int DIGIT_CNT_W     = 6;
    localparam int STEP_BITS       = 8;
    localparam int STEPS_PER_DIGIT = VALUE_W / STEP_BITS;
    localparam int STEP_CNT_W      = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_LEN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIGITS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIGITS_HIGH = 2'd2;

    // Reset values: radix 10 over "0123456789ABCDEF"
    localparam logic [BASE_LEN_W-1:0] BASE_LEN_RST    = 5'd10;
    localparam logic [CFG_DATA_W-1:0] DIGITS_LOW_RST  = 64'h3736353433323130;
    localparam logic [CFG_DATA_W-1:0] DIGITS_HIGH_RST = 64'h4645444342413938;

    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_SIGN,
        ST_DIGITS
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic push;
        logic emit_sign;
        logic emit_digit;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic radix_ok;
        logic neg;
        logic quot_zero;
        logic last_digit;
        logic out_free;
    } t_status;

endpackage

[hdl/sirt_ctrl.sv]
// Sequencer of the radix text converter: accept, check, divide, emit.
module sirt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  sirt_pkg::t_status i_status,
    output sirt_pkg::t_cmd   o_cmd,
    output logic             o_in_stall
);

    localparam logic [sirt_pkg::STEP_CNT_W-1:0] STEP_LAST =
        sirt_pkg::STEP_CNT_W'(sirt_pkg::STEPS_PER_DIGIT - 1);

    sirt_pkg::t_state r_state, n_state;
    logic [sirt_pkg::STEP_CNT_W-1:0] r_step, n_step;
    logic step_last;

    assign step_last  = (r_step == STEP_LAST);
    assign o_in_stall = (r_state != sirt_pkg::ST_IDLE);

    // Advance state and division step count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sirt_pkg::ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_step  = '0;
        unique case (r_state)
            sirt_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = sirt_pkg::ST_CHECK;
            end
            sirt_pkg::ST_CHECK: begin
                n_state = i_status.radix_ok ? sirt_pkg::ST_DIVIDE : sirt_pkg::ST_IDLE;
            end
            sirt_pkg::ST_DIVIDE: begin
                n_step = r_step + 1'b1;
                if (step_last && i_status.quot_zero) begin
                    n_state = i_status.neg ? sirt_pkg::ST_SIGN : sirt_pkg::ST_DIGITS;
                end
            end
            sirt_pkg::ST_SIGN: begin
                if (i_status.out_free) n_state = sirt_pkg::ST_DIGITS;
            end
            sirt_pkg::ST_DIGITS: begin
                if (i_status.out_free && i_status.last_digit) n_state = sirt_pkg::ST_IDLE;
            end
            default: n_state = sirt_pkg::ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            sirt_pkg::ST_IDLE:   o_cmd.load = i_in_valid;
            sirt_pkg::ST_CHECK:  ;
            sirt_pkg::ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                o_cmd.push     = step_last;
            end
            sirt_pkg::ST_SIGN:   o_cmd.emit_sign  = i_status.out_free;
            sirt_pkg::ST_DIGITS: o_cmd.emit_digit = i_status.out_free;
            default: ;
        endcase
    end

endmodule

[hdl/sirt_dp.sv]
// Datapath of the radix text converter: config, alphabet check, divider, digit stack, output.
`include "signed_int_to_radix_text_top_macros.svh"
module sirt_dp #(
    parameter int MAX_RADIX = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sirt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sirt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic signed [sirt_pkg::VALUE_W-1:0] i_value,
    input  logic                                i_out_stall,
    input  sirt_pkg::t_cmd                      i_cmd,
    output sirt_pkg::t_status                   o_status,
    output logic                                o_out_valid,
    output logic [sirt_pkg::CHAR_W-1:0]         o_character,
    output logic                                o_last_char
);

    localparam int RW = $clog2(MAX_RADIX + 1);
    localparam int DW = $clog2(MAX_RADIX);
    localparam int VW = sirt_pkg::VALUE_W;

    logic [sirt_pkg::BASE_LEN_W-1:0] r_alpha_len;
    logic [sirt_pkg::CFG_DATA_W-1:0] r_digits_low;
    logic [sirt_pkg::CFG_DATA_W-1:0] r_digits_high;
    logic [sirt_pkg::ALPHA_SIZE-1:0][sirt_pkg::CHAR_W-1:0] chars;

    logic [RW-1:0] r_radix, n_radix;
    logic [VW-1:0] r_mag, n_mag;
    logic [DW-1:0] r_rem, n_rem;
    logic          r_neg;
    logic [sirt_pkg::MAX_DIGITS-1:0][DW-1:0] r_stack;
    logic [sirt_pkg::DIGIT_CNT_W-1:0]        r_count;
    logic          r_out_valid;
    logic [sirt_pkg::CHAR_W-1:0] r_char;
    logic          r_last;
    logic          out_free;

    assign chars    = {r_digits_high, r_digits_low};
    assign out_free = !r_out_valid || !i_out_stall;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_len   <= sirt_pkg::BASE_LEN_RST;
            r_digits_low  <= sirt_pkg::DIGITS_LOW_RST;
            r_digits_high <= sirt_pkg::DIGITS_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sirt_pkg::REG_BASE_LEN:
                    r_alpha_len <= i_cfg_data[sirt_pkg::BASE_LEN_W-1:0];
                sirt_pkg::REG_DIGITS_LOW:  r_digits_low  <= i_cfg_data;
                sirt_pkg::REG_DIGITS_HIGH: r_digits_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective radix: length capped at MAX_RADIX and cut at first zero byte, zero if short or repeated
    always_comb begin
        logic [sirt_pkg::BASE_LEN_W-1:0] lim;
        logic [sirt_pkg::ALPHA_SIZE-1:0] inuse;
        logic [sirt_pkg::BASE_LEN_W-1:0] cnt;
        logic run;
        logic dup;
        lim = (r_alpha_len > sirt_pkg::BASE_LEN_W'(MAX_RADIX))
            ? sirt_pkg::BASE_LEN_W'(MAX_RADIX) : r_alpha_len;
        run = 1'b1;
        for (int k = 0; k < sirt_pkg::ALPHA_SIZE; k++) begin
            run = run && (sirt_pkg::BASE_LEN_W'(k) < lim) && (chars[k] != '0);
            inuse[k] = run;
        end
        cnt = sirt_pkg::BASE_LEN_W'($countones(inuse));
        dup = 1'b0;
        for (int i = 0; i < sirt_pkg::ALPHA_SIZE; i++) begin
            for (int j = i + 1; j < sirt_pkg::ALPHA_SIZE; j++) begin
                if (inuse[j] && (chars[i] == chars[j])) dup = 1'b1;
            end
        end
        n_radix = (cnt < sirt_pkg::BASE_LEN_W'(2) || dup) ? '0 : RW'(cnt);
    end

    // Hold the effective radix
    always_ff @(posedge i_clk) begin
        r_radix <= n_radix;
    end

    // Divide by the radix, eight dividend bits a cycle
    always_comb begin
        logic [DW:0]   t;
        logic [DW-1:0] rem;
        logic [VW-1:0] m;
        rem = r_rem;
        m   = r_mag;
        for (int b = 0; b < sirt_pkg::STEP_BITS; b++) begin
            t = {rem, m[VW-1]};
            m = {m[VW-2:0], 1'b0};
            if (t >= (DW+1)'(r_radix)) begin
                t    = t - (DW+1)'(r_radix);
                m[0] = 1'b1;
            end
            rem = t[DW-1:0];
        end
        n_mag = m;
        n_rem = rem;
    end

    // Load magnitude, step the divider, push and pop digits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_count <= '0;
        end else if (i_cmd.push) begin
            r_count <= r_count + 1'b1;
        end else if (i_cmd.emit_digit) begin
            r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= i_value[VW-1];
            r_mag <= i_value[VW-1] ? (VW'(0) - VW'(i_value)) : VW'(i_value);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_mag <= n_mag;
            r_rem <= i_cmd.push ? '0 : n_rem;
        end
        if (i_cmd.push) begin
            r_stack <= {r_stack[sirt_pkg::MAX_DIGITS-2:0], n_rem};
        end else if (i_cmd.emit_digit) begin
            r_stack <= {DW'(0), r_stack[sirt_pkg::MAX_DIGITS-1:1]};
        end
    end

    // Output register: load a character, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_char <= sirt_pkg::MINUS_CHAR;
            r_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_char <= chars[sirt_pkg::ALPHA_IDX_W'(r_stack[0])];
            r_last <= (r_count == sirt_pkg::DIGIT_CNT_W'(1));
        end
    end

    assign o_status.radix_ok   = (r_radix != '0);
    assign o_status.neg        = r_neg;
    assign o_status.quot_zero  = (n_mag == '0);
    assign o_status.last_digit = (r_count == sirt_pkg::DIGIT_CNT_W'(1));
    assign o_status.out_free   = out_free;

    assign o_out_valid = r_out_valid;
    assign o_character = r_char;
    assign o_last_char = r_last;

    `SIRT_ASSERT_SAME(a_push_room, i_cmd.push, r_count < sirt_pkg::DIGIT_CNT_W'(sirt_pkg::MAX_DIGITS))
    `SIRT_ASSERT_SAME(a_pop_nonempty, i_cmd.emit_digit, r_count != '0)
    `SIRT_ASSERT_SAME(a_emit_free, i_cmd.emit_sign || i_cmd.emit_digit, out_free)
    `SIRT_ASSERT_NEXT(a_divide_radix, i_cmd.div_step, r_radix != '0)

endmodule

[hdl/signed_int_to_radix_text_top.sv]
// Top level of the signed integer to radix text converter.
// Order: alphabet check (bad alphabet: no output), divider steps per digit, then characters.
// The input stays stalled until the last character of an item enters the output register.
// The divider retires 8 dividend bits a cycle against the radix.
// Characters leave one a cycle through an output register while i_out_stall is low.
// Reset: radix 10, alphabet "0123456789ABCDEF", no item held, output not valid.
module signed_int_to_radix_text_top #(
    parameter int MAX_RADIX = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sirt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sirt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [sirt_pkg::VALUE_W-1:0] i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [sirt_pkg::CHAR_W-1:0]         o_character,
    output logic                                o_last_char
);

    sirt_pkg::t_cmd    cmd;
    sirt_pkg::t_status status;

    // Sequence each item
    sirt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Hold config, divide and emit characters
    sirt_dp #(
        .MAX_RADIX (MAX_RADIX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_value     (i_value),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_character (o_character),
        .o_last_char (o_last_char)
    );

endmodule
